// ===== rtl/core/lfu_pfm_pkg.sv =====
package lfu_pfm_pkg;

	localparam int PAGE_W      = 20;
	localparam int FRAME_IDX_W = 3;
	localparam int USE_W       = 16;

	typedef struct packed {
		logic start;
		logic rd_en;
		logic div_load;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic match_found;
		logic empty_found;
		logic out_full;
	} sts_t;

endpackage

// ===== rtl/core/lfu_pfm_ctrl.sv =====
module lfu_pfm_ctrl import lfu_pfm_pkg::*; #(
	parameter int FRAMES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sts_t                        sts,
	output cmd_t                        cmd,
	output logic [$clog2(FRAMES)-1:0]   scan_idx
);

	localparam int IW = $clog2(FRAMES);
	localparam int CW = IW;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	assign in_ready = (state_q == ST_IDLE);
	assign scan_idx = cnt_q[IW-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_d     = '0;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == CW'(FRAMES - 1)) begin
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.match_found || sts.empty_found) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_full) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/core/lfu_pfm_dp.sv =====
module lfu_pfm_dp import lfu_pfm_pkg::*; #(
	parameter int FRAMES     = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmd_t                        cmd,
	input  logic [$clog2(FRAMES)-1:0]   scan_idx,
	input  logic [PAGE_W-1:0]           page_number,
	input  logic                        out_ready,
	output sts_t                        sts,
	output logic                        out_valid,
	output logic [FRAME_IDX_W-1:0]      frame_index,
	output logic                        hit,
	output logic                        writeback,
	output logic [PAGE_W-1:0]           evicted_page,
	output logic [USE_W-1:0]            use_count
);

	localparam int IW      = $clog2(FRAMES);
	localparam int SW      = COUNT_BITS + IW;
	localparam int DIVISOR = FRAMES - 1;
	localparam int DIV_SH  = SW + $clog2(DIVISOR);
	localparam int RW      = SW + 1;
	// ceil(2^DIV_SH / DIVISOR): exact floor division for any SW-bit dividend
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << DIV_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic [PAGE_W-1:0]     page_mem  [FRAMES];
	logic [COUNT_BITS-1:0] count_mem [FRAMES];
	logic [FRAMES-1:0]     valid_q;

	logic [PAGE_W-1:0]     req_page_q;
	logic [PAGE_W-1:0]     rd_page_q;
	logic [COUNT_BITS-1:0] rd_count_q;
	logic                  rd_vld_s1;
	logic                  rd_first_s1;
	logic [IW-1:0]         rd_idx_s1;

	logic                  match_q, empty_q;
	logic [IW-1:0]         match_idx_q, empty_idx_q, min_idx_q;
	logic [COUNT_BITS-1:0] match_cnt_q, min_cnt_q;
	logic [PAGE_W-1:0]     min_page_q;
	logic [SW-1:0]         sum_q;
	logic [SW-1:0]         div_q;
	logic [COUNT_BITS-1:0] quot_q;

	logic                  out_valid_q, hit_q, wb_q;
	logic [FRAME_IDX_W-1:0] frame_index_q;
	logic [PAGE_W-1:0]     evicted_q;
	logic [USE_W-1:0]      use_count_q;

	logic                  rd_vbit, hit_now, empty_now;
	logic [SW+RW-1:0]      prod;
	logic [IW-1:0]         wr_idx;
	logic [COUNT_BITS-1:0] wr_count;
	logic                  evict;

	assign rd_vbit   = valid_q[rd_idx_s1];
	assign hit_now   = rd_vbit && (rd_page_q == req_page_q);
	assign empty_now = !rd_vbit;
	assign evict     = !match_q && !empty_q;

	assign prod = {{RW{1'b0}}, div_q} * {{SW{1'b0}}, RECIP};

	always_comb begin
		priority if (match_q) begin
			wr_idx   = match_idx_q;
			wr_count = (match_cnt_q == '1) ? match_cnt_q : match_cnt_q + 1'b1;
		end else if (empty_q) begin
			wr_idx   = empty_idx_q;
			wr_count = COUNT_BITS'(1);
		end else begin
			wr_idx   = min_idx_q;
			wr_count = quot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			page_mem[wr_idx]  <= req_page_q;
			count_mem[wr_idx] <= wr_count;
		end
		if (cmd.rd_en) begin
			rd_page_q  <= page_mem[scan_idx];
			rd_count_q <= count_mem[scan_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			match_q     <= 1'b0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.commit) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_vld_s1) begin
				if (rd_first_s1) begin
					match_q <= hit_now;
					empty_q <= empty_now;
				end else begin
					match_q <= match_q || hit_now;
					empty_q <= empty_q || empty_now;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_page_q <= page_number;
		end
		rd_first_s1 <= (scan_idx == '0);
		rd_idx_s1   <= scan_idx;
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				match_idx_q <= rd_idx_s1;
				match_cnt_q <= rd_count_q;
				empty_idx_q <= rd_idx_s1;
				min_idx_q   <= rd_idx_s1;
				min_cnt_q   <= rd_count_q;
				min_page_q  <= rd_page_q;
				sum_q       <= SW'(rd_count_q);
			end else begin
				if (hit_now && !match_q) begin
					match_idx_q <= rd_idx_s1;
					match_cnt_q <= rd_count_q;
				end
				if (empty_now && !empty_q) begin
					empty_idx_q <= rd_idx_s1;
				end
				if (rd_count_q < min_cnt_q) begin
					min_idx_q  <= rd_idx_s1;
					min_cnt_q  <= rd_count_q;
					min_page_q <= rd_page_q;
				end
				sum_q <= sum_q + SW'(rd_count_q);
			end
		end
		if (cmd.div_load) begin
			div_q <= sum_q - SW'(min_cnt_q);
		end
		if (cmd.div_step) begin
			quot_q <= prod[DIV_SH +: COUNT_BITS];
		end
		if (cmd.commit) begin
			frame_index_q <= FRAME_IDX_W'(wr_idx);
			hit_q         <= match_q;
			wb_q          <= evict;
			evicted_q     <= evict ? min_page_q : '0;
			use_count_q   <= USE_W'(wr_count);
		end
	end

	assign sts.match_found = match_q;
	assign sts.empty_found = empty_q;
	assign sts.out_full    = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign frame_index  = frame_index_q;
	assign hit          = hit_q;
	assign writeback    = wb_q;
	assign evicted_page = evicted_q;
	assign use_count    = use_count_q;

endmodule

// ===== rtl/core/lfu_page_frame_manager.sv =====
// Fully associative page-frame table with least-frequently-used replacement. One request is
// handled at a time. Frames are held in a single-read-port memory and scanned one per cycle.
// A hit or a fill into an empty frame goes straight to commit after the scan; an eviction
// adds a divide state for the reciprocal multiplication that forms the new frame's averaged
// count. The result beat is held in an output register until taken.
// No clearing pass after reset: only the valid bits are cleared.
module lfu_page_frame_manager import lfu_pfm_pkg::*; #(
	parameter int FRAMES     = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PAGE_W-1:0]      page_number,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FRAME_IDX_W-1:0] frame_index,
	output logic                   hit,
	output logic                   writeback,
	output logic [PAGE_W-1:0]      evicted_page,
	output logic [USE_W-1:0]       use_count
);

	cmd_t                      cmd;
	sts_t                      sts;
	logic [$clog2(FRAMES)-1:0] scan_idx;

	lfu_pfm_ctrl #(
		.FRAMES (FRAMES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd),
		.scan_idx (scan_idx)
	);

	lfu_pfm_dp #(
		.FRAMES     (FRAMES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.scan_idx     (scan_idx),
		.page_number  (page_number),
		.out_ready    (out_ready),
		.sts          (sts),
		.out_valid    (out_valid),
		.frame_index  (frame_index),
		.hit          (hit),
		.writeback    (writeback),
		.evicted_page (evicted_page),
		.use_count    (use_count)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in flight");

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && writeback))
		else $error("hit reported together with writeback");

	a_evicted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !writeback |-> evicted_page == '0)
		else $error("evicted page nonzero without writeback");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

endmodule
